[hdl/websocket_frame_encoder_top_macros.svh]
// ----------------------------------------------------------------------------
// websocket frame encoder assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_ENCODER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_ENCODER_TOP_MACROS_SVH

// implication checked in the same cycle
`define WSFE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle
`define WSFE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wsfe_pkg.sv]
// ----------------------------------------------------------------------------
// websocket frame encoder package
// operation codes, header constants and header byte selection
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsfe_pkg;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        LEN_SHORT,
        LEN_MID,
        LEN_LONG
    } len_class_t;

    localparam logic [7:0]  FIN_BIT      = 8'h80;
    localparam logic [7:0]  MASK_BIT     = 8'h80;
    localparam logic [7:0]  LEN_CODE16   = 8'd126;
    localparam logic [7:0]  LEN_CODE64   = 8'd127;
    localparam logic [62:0] LEN7_MAX     = 63'd125;
    localparam logic [62:0] LEN16_MAX    = 63'd65535;
    localparam logic [3:0]  KEY_AT_SHORT = 4'd2;
    localparam logic [3:0]  KEY_AT_MID   = 4'd4;
    localparam logic [3:0]  KEY_AT_LONG  = 4'd10;
    localparam logic [3:0]  LONG_EXT_TOP = 4'd9;

    function automatic logic [3:0] key_base(input len_class_t cls);
        logic [3:0] base;
        case (cls)
            LEN_SHORT: base = KEY_AT_SHORT;
            LEN_MID:   base = KEY_AT_MID;
            default:   base = KEY_AT_LONG;
        endcase
        return base;
    endfunction

    function automatic logic [3:0] hdr_last_idx(input len_class_t cls);
        return key_base(cls) + 4'd3;
    endfunction

    function automatic logic [7:0] hdr_byte(
        input logic [3:0]  idx,
        input len_class_t  cls,
        input logic [3:0]  opcode,
        input logic [62:0] len,
        input logic [31:0] key
    );
        logic [63:0] ext;
        logic [3:0]  base;
        logic [3:0]  key_off;
        logic [2:0]  ext_sel;
        logic [7:0]  code;
        logic [7:0]  res;
        ext     = {1'b0, len};
        base    = key_base(cls);
        key_off = idx - base;
        ext_sel = 3'(LONG_EXT_TOP - idx);
        case (cls)
            LEN_SHORT: code = {1'b0, len[6:0]};
            LEN_MID:   code = LEN_CODE16;
            default:   code = LEN_CODE64;
        endcase
        if (idx == 4'd0)
        begin
            res = FIN_BIT | {4'b0, opcode};
        end
        else if (idx == 4'd1)
        begin
            res = MASK_BIT | code;
        end
        else if (idx >= base)
        begin
            res = key[key_off[1:0]*8 +: 8];
        end
        else if (cls == LEN_MID)
        begin
            res = (idx == 4'd2) ? len[15:8] : len[7:0];
        end
        else
        begin
            res = ext[ext_sel*8 +: 8];
        end
        return res;
    endfunction

endpackage

[hdl/websocket_frame_encoder_top.sv]
// ----------------------------------------------------------------------------
// websocket frame encoder
// A start word loads opcode, payload length and mask key and emits the client
// frame header (FIN and MASK set) one byte per cycle while the output is not
// stalled: 6 bytes for lengths up to 125, 8 up to 65535, 14 above. A data word
// yields one masked payload byte, or the byte unmasked with misuse_error when
// no frame payload remains; data words stream at one per cycle while the output
// is not stalled. An input register parts the input from the output register,
// so a word is taken while a result waits, and passes through both in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_encoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [3:0]  opcode,
    input  logic [62:0] payload_length,
    input  logic [31:0] mask_key,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        end_of_frame,
    output logic        misuse_error
);
    import wsfe_pkg::*;

    logic        item_valid_reg, item_valid_next;
    op_t         item_op_reg, item_op_next;
    logic [3:0]  item_opcode_reg, item_opcode_next;
    logic [62:0] item_len_reg, item_len_next;
    logic [31:0] item_key_reg, item_key_next;
    logic [7:0]  item_data_reg, item_data_next;
    len_class_t  item_cls_reg, item_cls_next;
    logic [3:0]  hdr_idx_reg, hdr_idx_next;

    logic [31:0] key_store_reg, key_store_next;
    logic [1:0]  key_pos_reg, key_pos_next;
    logic [62:0] remaining_reg, remaining_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        out_eof_reg, out_eof_next;
    logic        out_err_reg, out_err_next;

    logic out_load;
    logic work;
    logic hdr_last;
    logic advance;
    logic in_take;

    always_comb
    begin
        out_load = !out_valid_reg || !out_stall;
        work     = item_valid_reg && out_load;
        hdr_last = (hdr_idx_reg == hdr_last_idx(item_cls_reg));
        advance  = work && ((item_op_reg == OP_DATA) || hdr_last);
        in_stall = item_valid_reg && !advance;
        in_take  = in_valid && !in_stall;

        item_op_next     = item_op_reg;
        item_opcode_next = item_opcode_reg;
        item_len_next    = item_len_reg;
        item_key_next    = item_key_reg;
        item_data_next   = item_data_reg;
        item_cls_next    = item_cls_reg;
        hdr_idx_next     = hdr_idx_reg;
        key_store_next   = key_store_reg;
        key_pos_next     = key_pos_reg;
        remaining_next   = remaining_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_eof_next     = out_eof_reg;
        out_err_next     = out_err_reg;

        if (work)
        begin
            if (item_op_reg == OP_DATA)
            begin
                out_last_next = 1'b1;
                if (remaining_reg == 63'd0)
                begin
                    out_byte_next = item_data_reg;
                    out_eof_next  = 1'b0;
                    out_err_next  = 1'b1;
                end
                else
                begin
                    out_byte_next  = item_data_reg ^ key_store_reg[key_pos_reg*8 +: 8];
                    out_eof_next   = (remaining_reg == 63'd1);
                    out_err_next   = 1'b0;
                    key_pos_next   = key_pos_reg + 2'd1;
                    remaining_next = remaining_reg - 63'd1;
                end
            end
            else
            begin
                out_byte_next = hdr_byte(hdr_idx_reg, item_cls_reg, item_opcode_reg,
                                         item_len_reg, item_key_reg);
                out_last_next = hdr_last;
                out_eof_next  = hdr_last && (item_len_reg == 63'd0);
                out_err_next  = 1'b0;
                hdr_idx_next  = hdr_idx_reg + 4'd1;
                if (hdr_last)
                begin
                    key_store_next = item_key_reg;
                    key_pos_next   = 2'd0;
                    remaining_next = item_len_reg;
                end
            end
        end

        if (in_take)
        begin
            item_op_next     = op_t'(operation);
            item_opcode_next = opcode;
            item_len_next    = payload_length;
            item_key_next    = mask_key;
            item_data_next   = data_byte;
            hdr_idx_next     = 4'd0;
            if (payload_length <= LEN7_MAX)
            begin
                item_cls_next = LEN_SHORT;
            end
            else if (payload_length <= LEN16_MAX)
            begin
                item_cls_next = LEN_MID;
            end
            else
            begin
                item_cls_next = LEN_LONG;
            end
        end

        item_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        out_valid_next  = out_load ? item_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            item_op_reg    <= OP_START;
            item_cls_reg   <= LEN_SHORT;
            hdr_idx_reg    <= 4'd0;
            key_store_reg  <= 32'd0;
            key_pos_reg    <= 2'd0;
            remaining_reg  <= 63'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            item_op_reg    <= item_op_next;
            item_cls_reg   <= item_cls_next;
            hdr_idx_reg    <= hdr_idx_next;
            key_store_reg  <= key_store_next;
            key_pos_reg    <= key_pos_next;
            remaining_reg  <= remaining_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload words, no reset
    always_ff @(posedge clk)
    begin
        item_opcode_reg <= item_opcode_next;
        item_len_reg    <= item_len_next;
        item_key_reg    <= item_key_next;
        item_data_reg   <= item_data_next;
        out_byte_reg    <= out_byte_next;
        out_last_reg    <= out_last_next;
        out_eof_reg     <= out_eof_next;
        out_err_reg     <= out_err_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_run  = out_last_reg;
    assign end_of_frame = out_eof_reg;
    assign misuse_error = out_err_reg;

endmodule

[hdl/wsfe_checker.sv]
// ----------------------------------------------------------------------------
// websocket frame encoder port checker
// checks output hold under stall, result flags and header streaming seen on the top level ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "websocket_frame_encoder_top_macros.svh"

module wsfe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        operation,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        last_of_run,
    input logic        end_of_frame,
    input logic        misuse_error
);
    import wsfe_pkg::*;

    logic in_is_data;

    assign in_is_data = in_valid && (operation == OP_DATA);

    `WSFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_byte), "stalled output word changed")
    `WSFE_ASSERT_NOW(a_err_flags, out_valid && misuse_error,
        last_of_run && !end_of_frame, "misuse word must close its run and not end a frame")
    `WSFE_ASSERT_NOW(a_eof_last, out_valid && end_of_frame,
        last_of_run, "frame end must close its run")
    `WSFE_ASSERT_NEXT(a_hdr_stream, out_valid && !out_stall && !last_of_run && !in_is_data,
        out_valid, "header bytes must stream without a gap")

endmodule

bind websocket_frame_encoder_top wsfe_checker u_wsfe_checker (.*);
